FILE: src/art_pkg.sv
`default_nettype none
package art_pkg;
	localparam int ENTRIES  = 64;
	localparam int IDX_BITS = $clog2(ENTRIES);
	localparam int CNT_BITS = 7;
	localparam int TAG_BITS = 16;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_CHECK  = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] range_start;
		logic [31:0] range_end;
		logic [15:0] tag_in;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic        hit;
		logic [15:0] tag_out;
		logic [32:0] added_count;
		logic [6:0]  entry_count;
		logic [32:0] address_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_TEST,
		ST_COMMIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_idx;
		logic rd;
		logic test;
		logic inc_idx;
		logic commit;
		logic respond;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_idx;
		logic found;
	} sts_t;
endpackage
`default_nettype wire

FILE: src/address_range_table_top.sv
`default_nettype none
// Address range table: up to 64 non-overlapping 32-bit ranges with tags.
// Command channel: drive cmd_in with start high while busy is low; the beat
// is taken at that edge. func selects insert, remove, lookup or check.
// Result channel: result is valid for exactly one cycle while done is high.
// The receiver cannot stall; every command yields one result.
// The controller walks the table one entry at a time, a registered read
// then a compare for each, and then commits and responds. It visits
// all 64 entries for insert and for misses, fewer when remove, lookup or
// check match early; busy stays high until done.
// Reset clears all valid bits and both counters at once; no clearing
// pass is needed, and commands are taken from the first cycle after reset.
module address_range_table_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire art_pkg::req_t cmd_in,
	output logic               done,
	output art_pkg::rsp_t      result
);
	import art_pkg::*;

	cmd_t cmd;
	sts_t sts;

	art_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	art_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .req(cmd_in), .cmd(cmd), .sts(sts),
		.done(done), .rsp(result)
	);
endmodule
`default_nettype wire

FILE: src/art_ctrl.sv
`default_nettype none
module art_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire art_pkg::sts_t sts,
	output art_pkg::cmd_t     cmd
);
	import art_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.clr_idx = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				cmd.test = 1'b1;
				// stop early on a match unless an insert still needs its free slot search
				if (sts.last_idx || sts.found) state_d = ST_COMMIT;
				else begin
					cmd.inc_idx = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				cmd.respond = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_respond_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> !cmd.respond) else $error("double response");
	a_commit_then_respond: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> cmd.respond) else $error("commit without response");
`endif
endmodule
`default_nettype wire

FILE: src/art_dpath.sv
`default_nettype none
module art_dpath (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire art_pkg::req_t req,
	input  wire art_pkg::cmd_t cmd,
	output art_pkg::sts_t     sts,
	output logic              done,
	output art_pkg::rsp_t     rsp
);
	import art_pkg::*;

	logic [31:0]         lows_mem  [ENTRIES];
	logic [31:0]         highs_mem [ENTRIES];
	logic [TAG_BITS-1:0] tags_mem  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;

	req_t                req_q;
	logic [IDX_BITS-1:0] idx_q;
	logic [31:0]         lo_q, hi_q;
	logic [TAG_BITS-1:0] tg_q;
	logic                vld_q;
	logic                found_q;
	logic [IDX_BITS-1:0] match_idx_q;
	logic [TAG_BITS-1:0] match_tag_q;
	logic                free_q;
	logic [IDX_BITS-1:0] free_idx_q;
	logic [CNT_BITS-1:0] entries_q;
	logic [32:0]         addr_q;
	rsp_t                rsp_q;
	logic                done_q;

	logic [31:0] q_end;
	logic        hit_now;
	logic [32:0] size;
	logic        order_ok;

	// lookup tests the single address
	assign q_end    = (req_q.func == FUNC_LOOKUP) ? req_q.range_start : req_q.range_end;
	assign order_ok = req_q.range_start <= req_q.range_end;
	assign size     = {1'b0, req_q.range_end} - {1'b0, req_q.range_start} + 33'd1;

	always_comb begin
		if (req_q.func == FUNC_REMOVE)
			hit_now = vld_q && lo_q == req_q.range_start && hi_q == req_q.range_end;
		else
			hit_now = vld_q && req_q.range_start <= hi_q && q_end >= lo_q;
	end

	assign sts.last_idx = (idx_q == IDX_BITS'(ENTRIES - 1));
	assign sts.found    = hit_now && (req_q.func != FUNC_INSERT);

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.rd) begin
			lo_q  <= lows_mem[idx_q];
			hi_q  <= highs_mem[idx_q];
			tg_q  <= tags_mem[idx_q];
		end
		if (cmd.commit && req_q.func == FUNC_INSERT && !found_q && free_q && order_ok) begin
			lows_mem[free_idx_q]  <= req_q.range_start;
			highs_mem[free_idx_q] <= req_q.range_end;
			tags_mem[free_idx_q]  <= req_q.tag_in[TAG_BITS-1:0];
		end
		if (cmd.test && hit_now && !found_q) begin
			match_idx_q <= idx_q;
			match_tag_q <= tg_q;
		end
		if (cmd.test && !vld_q && !free_q) free_idx_q <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			entries_q <= '0;
			addr_q    <= '0;
			idx_q     <= '0;
			vld_q     <= 1'b0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
		end else begin
			done_q <= cmd.respond;
			if (cmd.clr_idx) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.rd) vld_q <= valid_q[idx_q];
			if (cmd.test) begin
				if (hit_now) found_q <= 1'b1;
				if (!vld_q) free_q <= 1'b1;
			end
			if (cmd.commit) begin
				rsp_q <= '0;
				unique case (func_t'(req_q.func))
					FUNC_INSERT: begin
						if (!found_q && free_q && order_ok) begin
							valid_q[free_idx_q] <= 1'b1;
							entries_q           <= entries_q + 1'b1;
							addr_q              <= addr_q + size;
							rsp_q.ok            <= 1'b1;
							rsp_q.added_count   <= size;
						end
					end
					FUNC_REMOVE: begin
						if (found_q) begin
							valid_q[match_idx_q] <= 1'b0;
							entries_q            <= entries_q - 1'b1;
							addr_q               <= addr_q - size;
							rsp_q.ok             <= 1'b1;
						end
					end
					FUNC_LOOKUP: begin
						if (found_q) begin
							rsp_q.hit     <= 1'b1;
							rsp_q.tag_out <= 16'(match_tag_q);
						end
					end
					FUNC_CHECK: rsp_q.hit <= found_q && order_ok;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		rsp               = rsp_q;
		rsp.entry_count   = entries_q;
		rsp.address_count = addr_q;
	end
	assign done = done_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= CNT_BITS'(ENTRIES)) else $error("entry count overflow");
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_BITS'($countones(valid_q)) == entries_q) else $error("count mismatch");
	a_ok_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(rsp_q.ok && rsp_q.hit)) else $error("ok and hit together");
`endif
endmodule
`default_nettype wire

FILE: verif/tb_address_range_table_top.sv
`timescale 1ns / 100ps
`default_nettype none

import art_pkg::*;

class range_scoreboard;
	logic [31:0] lows[ENTRIES];
	logic [31:0] highs[ENTRIES];
	logic [15:0] tags[ENTRIES];
	bit          used[ENTRIES];
	int unsigned stored;
	logic [32:0] covered;
	rsp_t        pending[$];
	int          mismatches;
	int          orphans;

	function new();
		stored = 0;
		covered = '0;
		mismatches = 0;
		orphans = 0;
		foreach (used[i]) used[i] = 1'b0;
	endfunction

	function int overlap_slot(logic [31:0] s, logic [31:0] e);
		for (int i = 0; i < ENTRIES; i++)
			if (used[i] && s <= highs[i] && e >= lows[i])
				return i;
		return -1;
	endfunction

	// apply one accepted beat and queue its result
	function void note_command(req_t c);
		rsp_t r;
		int   slot;
		logic [32:0] size;
		r = '0;
		size = {1'b0, c.range_end} - {1'b0, c.range_start} + 33'd1;
		case (func_t'(c.func))
			FUNC_INSERT: begin
				if (c.range_start <= c.range_end && overlap_slot(c.range_start, c.range_end) < 0
						&& stored < ENTRIES) begin
					slot = 0;
					while (used[slot]) slot++;
					lows[slot] = c.range_start;
					highs[slot] = c.range_end;
					tags[slot] = c.tag_in;
					used[slot] = 1'b1;
					stored++;
					covered = covered + size;
					r.ok = 1'b1;
					r.added_count = size;
				end
			end
			FUNC_REMOVE: begin
				for (int i = 0; i < ENTRIES; i++)
					if (used[i] && lows[i] == c.range_start && highs[i] == c.range_end) begin
						used[i] = 1'b0;
						stored--;
						covered = covered - size;
						r.ok = 1'b1;
						break;
					end
			end
			FUNC_LOOKUP: begin
				slot = overlap_slot(c.range_start, c.range_start);
				if (slot >= 0) begin
					r.hit = 1'b1;
					r.tag_out = tags[slot];
				end
			end
			default: begin
				if (c.range_start <= c.range_end && overlap_slot(c.range_start, c.range_end) >= 0)
					r.hit = 1'b1;
			end
		endcase
		r.entry_count = stored[6:0];
		r.address_count = covered;
		pending.push_back(r);
	endfunction

	function void check_result(rsp_t got);
		rsp_t want;
		if (pending.size() == 0) begin
			orphans++;
			if (mismatches + orphans <= 10)
				$display("unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got.ok !== want.ok || got.hit !== want.hit || got.tag_out !== want.tag_out
				|| got.added_count !== want.added_count
				|| got.entry_count !== want.entry_count
				|| got.address_count !== want.address_count) begin
			mismatches++;
			if (mismatches + orphans <= 10)
				$display("mismatch: ok %b/%b hit %b/%b tag %h/%h added %h/%h entries %0d/%0d addrs %h/%h",
					want.ok, got.ok, want.hit, got.hit, want.tag_out, got.tag_out,
					want.added_count, got.added_count, want.entry_count, got.entry_count,
					want.address_count, got.address_count);
		end
	endfunction
endclass

module tb_address_range_table_top;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t cmd_in;
	rsp_t result;

	range_scoreboard table_model;
	int idle_pct;
	logic [31:0] pool_lo[$];
	logic [31:0] pool_hi[$];

	address_range_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd_in (cmd_in),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_address_range_table_top failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			table_model.check_result(result);
	end

	// present one beat, hold until taken
	task automatic send(func_t f, logic [31:0] s, logic [31:0] e, logic [15:0] t);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		cmd_in <= '{func: f, range_start: s, range_end: e, tag_in: t};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		table_model.note_command(cmd_in);
		@(negedge clk);
	endtask

	// random range, mostly narrow and in a small window so hits are common
	task automatic random_op();
		logic [31:0] s, e, span;
		int k, sel;
		s = $urandom_range(3) == 0 ? $urandom() : $urandom_range(4095);
		span = $urandom_range(7) == 0 ? $urandom() : $urandom_range(40);
		e = $urandom_range(15) == 0 ? $urandom() : s + span;
		sel = $urandom_range(99);
		if (sel < 40) begin
			send(FUNC_INSERT, s, e, 16'($urandom()));
			if (s <= e && pool_lo.size() < 200) begin
				pool_lo.push_back(s);
				pool_hi.push_back(e);
			end
		end else if (sel < 60 && pool_lo.size() > 0) begin
			k = $urandom_range(pool_lo.size() - 1);
			send(FUNC_REMOVE, pool_lo[k], pool_hi[k], 16'($urandom()));
			pool_lo.delete(k);
			pool_hi.delete(k);
		end else if (sel < 65) begin
			send(FUNC_REMOVE, s, e, 16'($urandom()));
		end else if (sel < 85) begin
			send(FUNC_LOOKUP, s, $urandom(), 16'($urandom()));
		end else begin
			send(FUNC_CHECK, s, e, 16'($urandom()));
		end
	endtask

	initial begin
		table_model = new();
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd_in = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every operation, each special case
		send(FUNC_LOOKUP, 32'h0, 32'h0, 16'h0);
		send(FUNC_INSERT, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
		send(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0);
		send(FUNC_INSERT, 32'h10, 32'h20, 16'h1);
		send(FUNC_REMOVE, 32'h0, 32'hFFFF_FFFE, 16'h0);
		send(FUNC_REMOVE, 32'h0, 32'hFFFF_FFFF, 16'h0);
		send(FUNC_INSERT, 32'h200, 32'h100, 16'h5);
		send(FUNC_CHECK, 32'h200, 32'h100, 16'h0);
		send(FUNC_INSERT, 32'h100, 32'h200, 16'hA5A5);
		send(FUNC_INSERT, 32'h80, 32'h300, 16'h5A5A);
		send(FUNC_INSERT, 32'h150, 32'h160, 16'h1);
		send(FUNC_CHECK, 32'h0, 32'h100, 16'h0);
		send(FUNC_CHECK, 32'h201, 32'h300, 16'h0);
		send(FUNC_LOOKUP, 32'h200, 32'h0, 16'h0);
		send(FUNC_LOOKUP, 32'h201, 32'h0, 16'h0);
		send(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
		for (int i = 0; i < 64; i++)
			send(FUNC_INSERT, 32'h1000 + i * 4, 32'h1000 + i * 4 + 1, i[15:0]);
		send(FUNC_REMOVE, 32'h100, 32'h200, 16'h0);
		send(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0);
		for (int i = 0; i < 64; i++)
			send(FUNC_REMOVE, 32'h1000 + i * 4, 32'h1000 + i * 4 + 1, 16'h0);

		for (int n = 0; n < 1300; n++) begin
			idle_pct = n < 430 ? 20 : (n < 860 ? 74 : 0);
			random_op();
		end
		start <= 1'b0;

		fork
			begin
				while (table_model.pending.size() != 0) @(posedge clk);
				repeat (20) @(posedge clk);
			end
			begin
				repeat (2000) @(posedge clk);
			end
		join_any
		if (table_model.pending.size() == 0 && table_model.mismatches == 0
				&& table_model.orphans == 0)
			$display("tb_address_range_table_top passed");
		else
			$display("tb_address_range_table_top failed");
		$finish;
	end
endmodule

`default_nettype wire

FILE: filelist.f
src/art_pkg.sv
src/art_ctrl.sv
src/art_dpath.sv
src/address_range_table_top.sv
verif/tb_address_range_table_top.sv
